// ===== sv/skt_pkg.sv =====
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Field widths, request codes, register map and the entry and control
// structs that pass between the top level and the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

   // table depth default
   localparam int CAPACITY_DEFAULT = 64;

   // field widths
   localparam int REQ_W    = 2;
   localparam int KEY_W    = 64;
   localparam int LEVEL_W  = 2;
   localparam int GAMES_W  = 5;
   localparam int POS_W    = 7;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   // request codes
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
   localparam logic [REQ_W-1:0] REQ_MATCH  = 2'd2;

   // register map (register index, taken from paddr[2])
   localparam logic REG_MAX_GAMES = 1'b0;
   localparam logic [GAMES_W-1:0] MAX_GAMES_RESET = 5'd10;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_RESOLVE
   } skt_state_type;

   // one table entry
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic               waiting;
      logic [GAMES_W-1:0] games;
   } skt_entry_type;

   // request fields broadcast to every cell
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   exclude_pos;
      logic [GAMES_W-1:0] max_games;
   } skt_query_type;

   // per-cycle commands to the cells
   typedef struct packed {
      logic cmp_en;
      logic ins_en;
   } skt_ctrl_type;

endpackage

`default_nettype wire

// ===== sv/skt_cell.sv =====
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key table
// Holds one entry, compares it against the broadcast request and, on an
// insert, keeps its entry, takes the new one or takes its lower neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
   parameter int INDEX   = 0,
   parameter int CNT_W   = 7
) (
   input  wire logic                    clock,
   input  wire skt_pkg::skt_ctrl_type   ctrl,
   input  wire skt_pkg::skt_query_type  query,
   input  wire logic [CNT_W-1:0]        entry_count,
   input  wire skt_pkg::skt_entry_type  new_entry,
   input  wire skt_pkg::skt_entry_type  prev_entry,
   input  wire logic                    prev_less,
   output skt_pkg::skt_entry_type       entry,
   output logic                         less,
   output logic                         equal,
   output logic                         qualify
);

   localparam int CMP_W = (CNT_W > skt_pkg::POS_W) ? CNT_W : skt_pkg::POS_W;

   skt_pkg::skt_entry_type entry_ff;
   logic less_ff;
   logic equal_ff;
   logic qualify_ff;
   logic occupied;
   logic less_in;
   logic equal_in;
   logic qualify_in;

   // compare the stored entry against the request
   always_comb begin
      occupied   = CNT_W'(INDEX) < entry_count;
      less_in    = occupied && (entry_ff.key < query.key);
      equal_in   = occupied && (entry_ff.key == query.key);
      qualify_in = occupied
                   && (CMP_W'(INDEX) != CMP_W'(query.exclude_pos))
                   && (entry_ff.games < query.max_games)
                   && (entry_ff.level == query.level)
                   && entry_ff.waiting;
   end

   // latch compare flags for the resolve cycle
   always_ff @(posedge clock) begin
      if (ctrl.cmp_en) begin
         less_ff    <= less_in;
         equal_ff   <= equal_in;
         qualify_ff <= qualify_in;
      end
   end

   // shift on insert: keep if below the slot, load new at the slot, else move up
   always_ff @(posedge clock) begin
      if (ctrl.ins_en && !less_ff) begin
         if (prev_less) begin
            entry_ff <= new_entry;
         end else begin
            entry_ff <= prev_entry;
         end
      end
   end

   assign entry   = entry_ff;
   assign less    = less_ff;
   assign equal   = equal_ff;
   assign qualify = qualify_ff;

endmodule

`default_nettype wire

// ===== sv/skt_pick.sv =====
// ----------------------------------------------------------------------------
// skt_pick: lowest set bit finder
// Isolates the lowest set bit of a flag vector and encodes its position.
// ----------------------------------------------------------------------------
`default_nettype none

module skt_pick #(
   parameter int N     = 65,
   parameter int IDX_W = 7
) (
   input  wire logic [N-1:0]     flags,
   output logic                  any,
   output logic [IDX_W-1:0]      index
);

   logic [N-1:0] low_hot;

   // isolate the lowest set bit, then OR its position together
   always_comb begin
      low_hot = flags & (~flags + N'(1));
      index   = '0;
      for (int i = 0; i < N; i++) begin
         if (low_hot[i]) begin
            index = index | IDX_W'(i);
         end
      end
   end

   assign any = |flags;

endmodule

`default_nettype wire

// ===== sv/sorted_key_table_top.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_top: sorted key table with lookup, insert and match
// Row of cells holding entries in ascending key order, a lowest-bit picker
// and a small sequencer with an output register and a register port.
// ----------------------------------------------------------------------------
// An accepted request passes through the compare stage, where every
// cell compares its entry against the request key and the match terms at
// once, and then the resolve stage, where the lowest qualifying cell
// or the first cell not below the key is picked and, for an insert, the
// cells above the slot shift up by one at the same edge. The result is
// registered at the end of the resolve stage, and a new request is taken
// in the resolve cycle, so its compare overlaps the previous result. A
// result that waits on rsp_ready holds the resolve stage and with it the
// next request.
`default_nettype none

module sorted_key_table_top #(
   parameter int CAPACITY = skt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [skt_pkg::REQ_W-1:0]     req_type,
   input  wire logic [skt_pkg::KEY_W-1:0]     req_key,
   input  wire logic [skt_pkg::LEVEL_W-1:0]   req_level,
   input  wire logic                          req_waiting,
   input  wire logic [skt_pkg::GAMES_W-1:0]   req_game_count,
   input  wire logic [skt_pkg::POS_W-1:0]     req_exclude_pos,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ok,
   output logic [skt_pkg::POS_W-1:0]          rsp_position,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [skt_pkg::ADDR_W-1:0]    csr_paddr,
   input  wire logic [skt_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [skt_pkg::DATA_W-1:0]         csr_prdata,
   output logic                               csr_pready
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   skt_pkg::skt_state_type state_ff;
   skt_pkg::skt_state_type state_in;

   logic [skt_pkg::REQ_W-1:0]   type_ff;
   logic [skt_pkg::KEY_W-1:0]   key_ff;
   logic [skt_pkg::LEVEL_W-1:0] level_ff;
   logic                        waiting_ff;
   logic [skt_pkg::GAMES_W-1:0] games_ff;
   logic [skt_pkg::POS_W-1:0]   exclude_ff;
   logic [skt_pkg::GAMES_W-1:0] max_games_ff;
   logic [CNT_W-1:0]            entry_count_ff;
   logic [CNT_W-1:0]            entry_count_in;

   logic                        rsp_valid_ff;
   logic                        rsp_ok_ff;
   logic                        rsp_ok_in;
   logic [skt_pkg::POS_W-1:0]   rsp_position_ff;
   logic [skt_pkg::POS_W-1:0]   rsp_position_in;

   logic                        accept;
   logic                        done;
   logic                        out_free;
   logic                        ins_go;
   logic                        found;
   logic                        full;
   logic                        pick_any;
   logic [CNT_W-1:0]            pick_index;
   logic [CAPACITY:0]           pick_flags;
   logic                        csr_write;

   skt_pkg::skt_ctrl_type       ctrl;
   skt_pkg::skt_query_type      query;
   skt_pkg::skt_entry_type      new_entry;
   skt_pkg::skt_entry_type      entry_vec [CAPACITY];
   skt_pkg::skt_entry_type      prev_vec  [CAPACITY];
   logic [CAPACITY-1:0]         less_vec;
   logic [CAPACITY-1:0]         prev_less_vec;
   logic [CAPACITY-1:0]         equal_vec;
   logic [CAPACITY-1:0]         qualify_vec;

   // register port: one register, always ready
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_games_ff <= skt_pkg::MAX_GAMES_RESET;
      end else if (csr_write && (csr_paddr[2] == skt_pkg::REG_MAX_GAMES)) begin
         max_games_ff <= csr_pwdata[skt_pkg::GAMES_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == skt_pkg::REG_MAX_GAMES) begin
         csr_prdata = skt_pkg::DATA_W'(max_games_ff);
      end
   end

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and stage controls
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      done      = 1'b0;
      ctrl      = '0;
      out_free  = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         skt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = skt_pkg::ST_COMPARE;
            end
         end
         skt_pkg::ST_COMPARE: begin
            ctrl.cmp_en = 1'b1;
            state_in    = skt_pkg::ST_RESOLVE;
         end
         skt_pkg::ST_RESOLVE: begin
            if (out_free) begin
               done      = 1'b1;
               req_ready = 1'b1;
               state_in  = req_valid ? skt_pkg::ST_COMPARE : skt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = skt_pkg::ST_IDLE;
         end
      endcase
      ctrl.ins_en = ins_go;
   end

   assign accept = req_valid && req_ready;

   // hold the request fields for the compare and resolve stages
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff    <= req_type;
         key_ff     <= req_key;
         level_ff   <= req_level;
         waiting_ff <= req_waiting;
         games_ff   <= req_game_count;
         exclude_ff <= req_exclude_pos;
      end
   end

   always_comb begin
      query.key         = key_ff;
      query.level       = level_ff;
      query.exclude_pos = exclude_ff;
      query.max_games   = max_games_ff;
      new_entry.key     = key_ff;
      new_entry.level   = level_ff;
      new_entry.waiting = waiting_ff;
      new_entry.games   = games_ff;
   end

   // cell chain: each cell sees its lower neighbor's entry and less flag
   assign prev_less_vec = {less_vec[CAPACITY-2:0], 1'b1};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_vec[i] = new_entry;
      end else begin : g_next
         assign prev_vec[i] = entry_vec[i-1];
      end

      skt_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .query       (query),
         .entry_count (entry_count_ff),
         .new_entry   (new_entry),
         .prev_entry  (prev_vec[i]),
         .prev_less   (prev_less_vec[i]),
         .entry       (entry_vec[i]),
         .less        (less_vec[i]),
         .equal       (equal_vec[i]),
         .qualify     (qualify_vec[i])
      );
   end

   // pick the first qualifying cell, or the first cell not below the key
   assign pick_flags = (type_ff == skt_pkg::REQ_MATCH) ? {1'b0, qualify_vec}
                                                       : {1'b1, ~less_vec};

   skt_pick #(
      .N     (CAPACITY + 1),
      .IDX_W (CNT_W)
   ) u_pick (
      .flags (pick_flags),
      .any   (pick_any),
      .index (pick_index)
   );

   // form the result and the insert commit
   always_comb begin
      found           = |equal_vec;
      full            = entry_count_ff == CNT_W'(CAPACITY);
      ins_go          = 1'b0;
      rsp_ok_in       = 1'b0;
      rsp_position_in = '0;
      case (type_ff)
         skt_pkg::REQ_LOOKUP: begin
            rsp_ok_in       = found;
            rsp_position_in = skt_pkg::POS_W'(pick_index);
         end
         skt_pkg::REQ_INSERT: begin
            if (!full) begin
               rsp_ok_in       = !found;
               rsp_position_in = skt_pkg::POS_W'(pick_index);
               ins_go          = done && !found;
            end
         end
         skt_pkg::REQ_MATCH: begin
            rsp_ok_in       = pick_any;
            rsp_position_in = pick_any ? skt_pkg::POS_W'(pick_index) : exclude_ff;
         end
         default: begin
            rsp_ok_in       = 1'b0;
            rsp_position_in = '0;
         end
      endcase
      entry_count_in = entry_count_ff + CNT_W'(ins_go);
   end

   // advance the fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else begin
         entry_count_ff <= entry_count_in;
      end
   end

   // output register: load on resolve, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ok_ff       <= rsp_ok_in;
         rsp_position_ff <= rsp_position_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_position = rsp_position_ff;

   // checks
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      ins_go |=> entry_count_ff == $past(entry_count_ff) + CNT_W'(1))
      else $error("fill count did not advance on insert");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      entry_count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_no_take_in_compare: assert property (@(posedge clock) disable iff (reset)
      (state_ff == skt_pkg::ST_COMPARE) |-> !req_ready)
      else $error("request taken during compare");

   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid)
      else $error("resolved result not presented");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      ins_go |-> !full && !found)
      else $error("insert committed into full table or over present key");

endmodule

`default_nettype wire

// ===== sim/sorted_key_table_top_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_key_table_top_tb: self-checking bench for the sorted key table
// Feeds lookup, insert and waiting-match requests through the request
// channel, tracks the table in a shadow copy and compares every response
// field by field. max_games is rewritten between phases while the table
// grows from empty to full, with random stalls on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_top_tb;

   localparam int HALF_PERIOD    = 5;
   localparam int TABLE_DEPTH    = skt_pkg::CAPACITY_DEFAULT;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 225;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   // code with no operation behind it
   localparam logic [skt_pkg::REQ_W-1:0]  REQ_UNUSED     = 2'd3;
   localparam logic [skt_pkg::ADDR_W-1:0] MAX_GAMES_ADDR = {skt_pkg::REG_MAX_GAMES, 2'b00};

   typedef struct {
      logic [skt_pkg::REQ_W-1:0]   kind;
      logic [skt_pkg::KEY_W-1:0]   key;
      logic [skt_pkg::LEVEL_W-1:0] level;
      logic                        waiting;
      logic [skt_pkg::GAMES_W-1:0] games;
      logic [skt_pkg::POS_W-1:0]   exclude_pos;
   } table_request_type;

   typedef struct {
      logic [skt_pkg::REQ_W-1:0] kind;
      logic [skt_pkg::KEY_W-1:0] key;
      logic                      ok;
      logic [skt_pkg::POS_W-1:0] position;
   } table_answer_type;

   // per-phase max_games setting and table fill target
   int phase_max_games [PHASES] = '{31, 1, 0, 5, 20, 10};
   int phase_fill      [PHASES] = '{12, 24, 36, 48, 64, 64};

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [skt_pkg::REQ_W-1:0]    req_type;
   logic [skt_pkg::KEY_W-1:0]    req_key;
   logic [skt_pkg::LEVEL_W-1:0]  req_level;
   logic                         req_waiting;
   logic [skt_pkg::GAMES_W-1:0]  req_game_count;
   logic [skt_pkg::POS_W-1:0]    req_exclude_pos;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_ok;
   logic [skt_pkg::POS_W-1:0]    rsp_position;
   logic                         csr_psel;
   logic                         csr_penable;
   logic                         csr_pwrite;
   logic [skt_pkg::ADDR_W-1:0]   csr_paddr;
   logic [skt_pkg::DATA_W-1:0]   csr_pwdata;
   logic [skt_pkg::DATA_W-1:0]   csr_prdata;
   logic                         csr_pready;

   // shadow of the table contents
   skt_pkg::skt_entry_type       shadow_table [TABLE_DEPTH];
   int                           shadow_count;
   logic [skt_pkg::GAMES_W-1:0]  shadow_max_games;

   table_request_type   request_backlog [$];
   table_answer_type    table_answers [$];
   table_request_type   next_request;
   table_answer_type    oldest_answer;

   // keys queued for insertion that the table will hold
   logic [skt_pkg::KEY_W-1:0]    known_keys [$];
   bit                           key_known [logic [skt_pkg::KEY_W-1:0]];

   bit                  req_busy;
   bit                  idle_on;
   bit                  hold_sender;
   bit                  long_hold_request;
   int                  send_gap_left;
   int                  recv_stall_left;
   int                  long_hold_left;
   int                  quiet_cycles;
   int                  fail_count;
   int                  lookups_seen;
   int                  inserts_seen;
   int                  matches_seen;
   int                  unused_seen;
   int                  ok_seen;
   int                  settings_seen;
   int                  peak_fill;

   sorted_key_table_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_key         (req_key),
      .req_level       (req_level),
      .req_waiting     (req_waiting),
      .req_game_count  (req_game_count),
      .req_exclude_pos (req_exclude_pos),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_position    (rsp_position),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // ------------------------------------------------------------------
   // helpers
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %0h expected %0h", what, got, want);
      fail_count++;
   endtask

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      else if (r < 92) return $urandom_range(1, 3);
      else return $urandom_range(6, 40);
   endfunction

   // number of entries with a key below k
   function automatic int slot_for(input logic [skt_pkg::KEY_W-1:0] k);
      int i;
      int slot;
      slot = 0;
      for (i = 0; i < shadow_count; i++) begin
         if (shadow_table[i].key < k) slot = i + 1;
      end
      return slot;
   endfunction

   // compute the response to one request and apply it to the shadow table
   function automatic table_answer_type table_answer(input table_request_type rq);
      table_answer_type ans;
      int               slot;
      int               i;
      bit               hit;
      ans.kind     = rq.kind;
      ans.key      = rq.key;
      ans.ok       = 1'b0;
      ans.position = '0;
      case (rq.kind)
         skt_pkg::REQ_LOOKUP: begin
            slot = slot_for(rq.key);
            ans.position = skt_pkg::POS_W'(slot);
            ans.ok = (slot < shadow_count) && (shadow_table[slot].key == rq.key);
         end
         skt_pkg::REQ_INSERT: begin
            if (shadow_count < TABLE_DEPTH) begin
               slot = slot_for(rq.key);
               ans.position = skt_pkg::POS_W'(slot);
               hit = (slot < shadow_count) && (shadow_table[slot].key == rq.key);
               if (!hit) begin
                  // shift higher entries up and store the new one
                  for (i = shadow_count; i > slot; i--)
                     shadow_table[i] = shadow_table[i-1];
                  shadow_table[slot].key     = rq.key;
                  shadow_table[slot].level   = rq.level;
                  shadow_table[slot].waiting = rq.waiting;
                  shadow_table[slot].games   = rq.games;
                  shadow_count++;
                  ans.ok = 1'b1;
               end
            end
         end
         skt_pkg::REQ_MATCH: begin
            ans.position = rq.exclude_pos;
            hit = 1'b0;
            for (i = 0; i < shadow_count; i++) begin
               if (!hit && skt_pkg::POS_W'(i) != rq.exclude_pos &&
                   shadow_table[i].games < shadow_max_games &&
                   shadow_table[i].level == rq.level && shadow_table[i].waiting) begin
                  hit = 1'b1;
                  ans.ok = 1'b1;
                  ans.position = skt_pkg::POS_W'(i);
               end
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   function automatic void queue_request(input logic [skt_pkg::REQ_W-1:0] kind,
                                         input logic [skt_pkg::KEY_W-1:0] key,
                                         input logic [skt_pkg::LEVEL_W-1:0] level,
                                         input logic waiting,
                                         input logic [skt_pkg::GAMES_W-1:0] games,
                                         input logic [skt_pkg::POS_W-1:0] exclude_pos);
      table_request_type rq;
      rq.kind        = kind;
      rq.key         = key;
      rq.level       = level;
      rq.waiting     = waiting;
      rq.games       = games;
      rq.exclude_pos = exclude_pos;
      request_backlog.push_back(rq);
      if (kind == skt_pkg::REQ_INSERT && !key_known.exists(key) &&
          known_keys.size() < TABLE_DEPTH) begin
         key_known[key] = 1'b1;
         known_keys.push_back(key);
      end
   endfunction

   // random, small, near the top, or packed text
   function automatic logic [skt_pkg::KEY_W-1:0] fresh_key();
      logic [skt_pkg::KEY_W-1:0] k;
      int                        len;
      int                        b;
      case ($urandom_range(3))
         0: k = {$urandom, $urandom};
         1: k = skt_pkg::KEY_W'($urandom_range(255));
         2: k = ~skt_pkg::KEY_W'($urandom_range(255));
         default: begin
            len = $urandom_range(1, 8);
            k = '0;
            for (b = 0; b < 8; b++)
               k = {k[skt_pkg::KEY_W-9:0],
                    (b < len) ? 8'(8'h41 + $urandom_range(25)) : 8'h00};
         end
      endcase
      return k;
   endfunction

   function automatic logic [skt_pkg::KEY_W-1:0] held_key();
      if (known_keys.size() == 0) return fresh_key();
      return known_keys[$urandom_range(known_keys.size() - 1)];
   endfunction

   function automatic logic [skt_pkg::GAMES_W-1:0] pick_games();
      if ($urandom_range(1)) return skt_pkg::GAMES_W'($urandom_range(12));
      return skt_pkg::GAMES_W'($urandom_range(31));
   endfunction

   // new inserts are spread so the table reaches target by the phase end
   function automatic void queue_random(input int target, input int remaining);
      int                          needed;
      int                          pick;
      logic [skt_pkg::KEY_W-1:0]   k;
      logic [skt_pkg::POS_W-1:0]   excl;
      needed = target - known_keys.size();
      if (needed > 0 && $urandom_range(remaining - 1) < needed) begin
         k = fresh_key();
         while (key_known.exists(k)) k = fresh_key();
         queue_request(skt_pkg::REQ_INSERT, k, skt_pkg::LEVEL_W'($urandom),
                       ($urandom_range(3) != 0), pick_games(),
                       skt_pkg::POS_W'($urandom));
         return;
      end
      pick = $urandom_range(99);
      if ($urandom_range(5) == 0) excl = skt_pkg::POS_W'($urandom);
      else excl = skt_pkg::POS_W'($urandom_range(known_keys.size()));
      if (pick < 38) begin
         case ($urandom_range(3))
            0, 1: k = held_key();
            2:    k = held_key() + ($urandom_range(1) ? 64'd1 : -64'd1);
            default: k = fresh_key();
         endcase
         queue_request(skt_pkg::REQ_LOOKUP, k, skt_pkg::LEVEL_W'($urandom),
                       1'($urandom), skt_pkg::GAMES_W'($urandom),
                       skt_pkg::POS_W'($urandom));
      end else if (pick < 76) begin
         queue_request(skt_pkg::REQ_MATCH, {$urandom, $urandom},
                       skt_pkg::LEVEL_W'($urandom), 1'($urandom),
                       skt_pkg::GAMES_W'($urandom), excl);
      end else if (pick < 95) begin
         // duplicates until full, then any key against a full table
         if (known_keys.size() >= TABLE_DEPTH && $urandom_range(1)) k = fresh_key();
         else k = held_key();
         queue_request(skt_pkg::REQ_INSERT, k, skt_pkg::LEVEL_W'($urandom),
                       1'($urandom), skt_pkg::GAMES_W'($urandom),
                       skt_pkg::POS_W'($urandom));
      end else begin
         queue_request(REQ_UNUSED, {$urandom, $urandom}, skt_pkg::LEVEL_W'($urandom),
                       1'($urandom), skt_pkg::GAMES_W'($urandom),
                       skt_pkg::POS_W'($urandom));
      end
   endfunction

   task automatic csr_transfer(input logic wr, input logic [skt_pkg::ADDR_W-1:0] addr,
                               input logic [skt_pkg::DATA_W-1:0] wdata,
                               output logic [skt_pkg::DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic verify_max_games();
      logic [skt_pkg::DATA_W-1:0] rdata;
      csr_transfer(1'b0, MAX_GAMES_ADDR, '0, rdata);
      if (rdata !== skt_pkg::DATA_W'(shadow_max_games))
         report_mismatch("max_games readback", 64'(rdata), 64'(shadow_max_games));
   endtask

   // upper data bits carry junk that the register must drop
   task automatic set_max_games(input logic [skt_pkg::GAMES_W-1:0] value);
      logic [skt_pkg::DATA_W-1:0] wdata;
      logic [skt_pkg::DATA_W-1:0] rdata;
      wdata = $urandom;
      wdata[skt_pkg::GAMES_W-1:0] = value;
      csr_transfer(1'b1, MAX_GAMES_ADDR, wdata, rdata);
      shadow_max_games = value;
      settings_seen++;
      verify_max_games();
   endtask

   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_busy || table_answers.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // request driver: launch the next item once the previous one transferred
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset && !req_busy) begin
         if (send_gap_left > 0) begin
            send_gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() > 0 && !hold_sender) begin
            next_request = request_backlog.pop_front();
            req_type        <= next_request.kind;
            req_key         <= next_request.key;
            req_level       <= next_request.level;
            req_waiting     <= next_request.waiting;
            req_game_count  <= next_request.games;
            req_exclude_pos <= next_request.exclude_pos;
            req_valid       <= 1'b1;
            req_busy = 1'b1;
            if (idle_on) send_gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // response receiver: random stalls plus one long hold when asked
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_request) begin
         long_hold_request = 1'b0;
         long_hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (recv_stall_left > 0) begin
         recv_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (idle_on) recv_stall_left = pick_gap();
      end
   end

   // ------------------------------------------------------------------
   // monitor: predict on each request transfer, check each response
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            next_request.kind        = req_type;
            next_request.key         = req_key;
            next_request.level       = req_level;
            next_request.waiting     = req_waiting;
            next_request.games       = req_game_count;
            next_request.exclude_pos = req_exclude_pos;
            table_answers.push_back(table_answer(next_request));
            if (shadow_count > peak_fill) peak_fill = shadow_count;
            case (req_type)
               skt_pkg::REQ_LOOKUP: lookups_seen++;
               skt_pkg::REQ_INSERT: inserts_seen++;
               skt_pkg::REQ_MATCH:  matches_seen++;
               default:             unused_seen++;
            endcase
            req_busy = 1'b0;
         end
         if (rsp_valid && rsp_ready) begin
            if (table_answers.size() == 0) begin
               report_mismatch("response with nothing awaited", 64'(rsp_position), 64'd0);
            end else begin
               oldest_answer = table_answers.pop_front();
               if (oldest_answer.ok) ok_seen++;
               if (rsp_ok !== oldest_answer.ok)
                  report_mismatch($sformatf("ok, request %0d key %0h", oldest_answer.kind,
                                  oldest_answer.key), 64'(rsp_ok), 64'(oldest_answer.ok));
               if (rsp_position !== oldest_answer.position)
                  report_mismatch($sformatf("position, request %0d key %0h",
                                  oldest_answer.kind, oldest_answer.key),
                                  64'(rsp_position), 64'(oldest_answer.position));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: end the run when nothing transfers for too long
   // ------------------------------------------------------------------
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_psel && csr_penable))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // sequence: reset, directed requests, then random phases
   // ------------------------------------------------------------------
   initial begin
      int ph;
      int n;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = skt_pkg::REQ_LOOKUP;
      req_key           = '0;
      req_level         = '0;
      req_waiting       = 1'b0;
      req_game_count    = '0;
      req_exclude_pos   = '0;
      rsp_ready         = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      shadow_count      = 0;
      shadow_max_games  = skt_pkg::MAX_GAMES_RESET;
      req_busy          = 1'b0;
      idle_on           = 1'b1;
      hold_sender       = 1'b0;
      long_hold_request = 1'b0;
      send_gap_left     = 0;
      recv_stall_left   = 0;
      long_hold_left    = 0;
      fail_count        = 0;
      lookups_seen      = 0;
      inserts_seen      = 0;
      matches_seen      = 0;
      unused_seen       = 0;
      ok_seen           = 0;
      settings_seen     = 0;
      peak_fill         = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      verify_max_games();

      // empty table, unused code, extreme keys, duplicates
      queue_request(skt_pkg::REQ_LOOKUP, 64'd5, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd0, 1'b1, 5'd0, 7'd0);
      queue_request(REQ_UNUSED, '1, 2'd3, 1'b1, 5'd31, 7'd127);
      queue_request(skt_pkg::REQ_INSERT, 64'h8000_0000_0000_0000, 2'd3, 1'b1, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_INSERT, 64'd0, 2'd0, 1'b1, 5'd31, 7'd0);
      queue_request(skt_pkg::REQ_INSERT, '1, 2'd3, 1'b0, 5'd9, 7'd0);
      queue_request(skt_pkg::REQ_INSERT, 64'h4142_4300_0000_0000, 2'd2, 1'b1, 5'd9, 7'd0);
      queue_request(skt_pkg::REQ_INSERT, 64'd0, 2'd1, 1'b1, 5'd1, 7'd0);
      queue_request(skt_pkg::REQ_INSERT, '1, 2'd0, 1'b1, 5'd1, 7'd0);
      // found and not found on both sides of stored keys
      queue_request(skt_pkg::REQ_LOOKUP, 64'd0, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_LOOKUP, '1, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_LOOKUP, 64'd1, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_LOOKUP, 64'h8000_0000_0000_0001, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_LOOKUP, 64'h4142_4300_0000_0000, 2'd0, 1'b0, 5'd0, 7'd0);
      // matches: hit, excluded hit, exclude beyond the table, over the game limit
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd3, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd3, 1'b0, 5'd0, 7'd2);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd3, 1'b0, 5'd0, 7'd127);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd0, 1'b0, 5'd0, 7'd0);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd2, 1'b0, 5'd0, 7'd64);
      queue_request(skt_pkg::REQ_MATCH, '0, 2'd2, 1'b0, 5'd0, 7'd1);
      queue_request(skt_pkg::REQ_INSERT, 64'h4142_4300_0000_0001, 2'd1, 1'b1, 5'd10, 7'd0);
      queue_request(skt_pkg::REQ_MATCH, '1, 2'd1, 1'b1, 5'd31, 7'd5);
      queue_request(REQ_UNUSED, '0, 2'd0, 1'b0, 5'd0, 7'd0);
      wait_drained();

      for (ph = 0; ph < PHASES; ph++) begin
         set_max_games(skt_pkg::GAMES_W'(phase_max_games[ph]));
         idle_on = (ph != 2);
         for (n = 0; n < PHASE_ITEMS; n++)
            queue_random(phase_fill[ph], PHASE_ITEMS - n);
         if (ph == 1) begin
            // stall responses long enough to back up the request side
            while (request_backlog.size() > 150) @(posedge clock);
            long_hold_request = 1'b1;
         end
         if (ph == 3) begin
            // pause the sender until every response is in
            while (request_backlog.size() > 110) @(posedge clock);
            hold_sender = 1'b1;
            while (req_busy || table_answers.size() != 0) @(posedge clock);
            repeat (SETTLE_CYCLES) @(posedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      $display("Covered %0d lookups, %0d inserts, %0d matches, %0d unused codes, %0d ok",
               lookups_seen, inserts_seen, matches_seen, unused_seen, ok_seen);
      $display("Table filled to %0d of %0d over %0d max_games settings, %0d mismatches",
               peak_fill, TABLE_DEPTH, settings_seen, fail_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
